>>> hw/rtl/iir3mc_pkg.sv
// types and constants for the third-order iir filter core and its history memory word
package iir3mc_pkg;

  // sample and coefficient formats
  localparam int SMP_W  = 24;
  localparam int COEF_W = 32;
  localparam int FRAC   = 28;
  localparam int PROD_W = SMP_W + COEF_W;
  // seven products of 56 bits sum without overflow in 59 bits
  localparam int ACC_W  = PROD_W + 3;

  localparam int CHAN_W   = 3;
  localparam int CFG_IW   = 3;
  localparam int NUM_COEF = 7;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // function codes
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // coefficient register indexes
  localparam logic [CFG_IW-1:0] REG_A0 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_A1 = 3'd1;
  localparam logic [CFG_IW-1:0] REG_A2 = 3'd2;
  localparam logic [CFG_IW-1:0] REG_A3 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_B1 = 3'd4;
  localparam logic [CFG_IW-1:0] REG_B2 = 3'd5;
  localparam logic [CFG_IW-1:0] REG_B3 = 3'd6;

  localparam coef_t A0_RESET = 32'sh1000_0000;

  localparam smp_t SMP_MAX = 24'sh7f_ffff;
  localparam smp_t SMP_MIN = 24'sh80_0000;

  // one channel's history, one memory word
  typedef struct packed {
    smp_t x1;
    smp_t x2;
    smp_t x3;
    smp_t y1;
    smp_t y2;
    smp_t y3;
  } hist_t;

  // item context carried down the pipe
  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] chan;
    logic              inr;
    smp_t              x;
    hist_t             h;
  } item_t;

endpackage

>>> hw/rtl/iir3mc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module iir3mc_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/third_order_iir_filter_multichannel_core.sv
// third-order direct form i iir filter with per-channel history in a ram
//
//  port group  dir  handshake              payload
//  smp         in   smp_valid / smp_stall  func, chan, sample_in
//  res         out  res_valid / res_stall  chan_out, sample_out
//  cfg         in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a word passes stages 1 to 4 and the output register to res_valid. words
// for different channels are taken one per cycle unless smp_stall holds
// them; a word for a channel with an older word in the pipe waits until
// that word leaves stage 4, set by the history ram read-modify-write loop.
// history reads as zero after reset or a clear through per-channel valid bits.
// res_stall holds the output register and backs the pipe up to smp_stall.
module third_order_iir_filter_multichannel_core #(
  parameter int CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                smp_valid,
  output logic                                smp_stall,
  input  logic                                func,
  input  logic [iir3mc_pkg::CHAN_W-1:0]       chan,
  input  logic signed [iir3mc_pkg::SMP_W-1:0] sample_in,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [iir3mc_pkg::CHAN_W-1:0]       chan_out,
  output logic signed [iir3mc_pkg::SMP_W-1:0] sample_out,
  // coefficient write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iir3mc_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [iir3mc_pkg::COEF_W-1:0]       cfg_data
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HW    = $bits(iir3mc_pkg::hist_t);
  localparam logic [8:0] CH_LIM = 9'(CHANNELS);

  localparam iir3mc_pkg::acc_t ACC_ROUND = iir3mc_pkg::acc_t'(1) <<< (iir3mc_pkg::FRAC - 1);
  localparam iir3mc_pkg::acc_t ACC_MAX   = iir3mc_pkg::acc_t'(iir3mc_pkg::SMP_MAX);
  localparam iir3mc_pkg::acc_t ACC_MIN   = iir3mc_pkg::acc_t'(iir3mc_pkg::SMP_MIN);

  iir3mc_pkg::coef_t coef [iir3mc_pkg::NUM_COEF];

  logic [CHANNELS-1:0] hvld;

  logic                s1_v, s2_v, s3_v, s4_v;
  iir3mc_pkg::item_t   s1, s2, s3, s4;
  logic                s1_hv;
  iir3mc_pkg::prod_t   p2 [7];
  iir3mc_pkg::acc_t    q3 [4];
  iir3mc_pkg::acc_t    t4 [2];

  logic                rdy1, rdy2, rdy3, rdy4, out_free;
  logic                hazard, accept;
  logic [8:0]          chan_ext;
  logic [CW-1:0]       rd_idx, wr_idx;
  logic                in_range;
  logic [HW-1:0]       ram_rdata;
  iir3mc_pkg::hist_t   h1;
  logic                retire, ram_we, clr_retire;
  iir3mc_pkg::hist_t   wb;
  iir3mc_pkg::acc_t    acc, q;
  iir3mc_pkg::smp_t    y, res_next;

  // coefficient registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[iir3mc_pkg::REG_A0] <= iir3mc_pkg::A0_RESET;
      for (int i = 1; i < iir3mc_pkg::NUM_COEF; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index inside {[iir3mc_pkg::REG_A0:iir3mc_pkg::REG_B3]})) begin
      coef[cfg_index] <= iir3mc_pkg::coef_t'(cfg_data);
    end
  end

  // pipe flow: a stage loads when it is empty or its content moves on
  assign out_free = !res_valid || !res_stall;
  assign rdy4     = !s4_v || out_free;
  assign rdy3     = !s3_v || rdy4;
  assign rdy2     = !s2_v || rdy3;
  assign rdy1     = !s1_v || rdy2;

  // same-channel interlock over all stages ahead of writeback
  assign hazard = (s1_v && s1.chan == chan) || (s2_v && s2.chan == chan) ||
                  (s3_v && s3.chan == chan) || (s4_v && s4.chan == chan);

  assign smp_stall = rst || !rdy1 || hazard;
  assign accept    = smp_valid && !smp_stall;

  assign chan_ext = 9'(chan);
  assign rd_idx   = chan_ext[CW-1:0];
  assign in_range = chan_ext < CH_LIM;

  // history ram, one word per channel
  iir3mc_ram #(
    .WIDTH(HW),
    .DEPTH(CHANNELS)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx),
    .wdata(wb),
    .re   (accept),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  // stage 1: item taken, history read issued
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (rdy1) begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && accept) begin
      s1.func <= func;
      s1.chan <= chan;
      s1.inr  <= in_range;
      s1.x    <= sample_in;
      s1.h    <= '0;
      s1_hv   <= in_range && hvld[rd_idx];
    end
  end

  // history as read, zero for an out-of-range channel or one never written since reset or clear
  assign h1 = s1_hv ? iir3mc_pkg::hist_t'(ram_rdata) : '0;

  // stage 2: seven products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (rdy2) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2.func <= s1.func;
      s2.chan <= s1.chan;
      s2.inr  <= s1.inr;
      s2.x    <= s1.x;
      s2.h    <= h1;
      p2[0]   <= iir3mc_pkg::prod_t'(coef[iir3mc_pkg::REG_A0]) * iir3mc_pkg::prod_t'(s1.x);
      p2[1]   <= iir3mc_pkg::prod_t'(coef[iir3mc_pkg::REG_A1]) * iir3mc_pkg::prod_t'(h1.x1);
      p2[2]   <= iir3mc_pkg::prod_t'(coef[iir3mc_pkg::REG_A2]) * iir3mc_pkg::prod_t'(h1.x2);
      p2[3]   <= iir3mc_pkg::prod_t'(coef[iir3mc_pkg::REG_A3]) * iir3mc_pkg::prod_t'(h1.x3);
      p2[4]   <= iir3mc_pkg::prod_t'(coef[iir3mc_pkg::REG_B1]) * iir3mc_pkg::prod_t'(h1.y1);
      p2[5]   <= iir3mc_pkg::prod_t'(coef[iir3mc_pkg::REG_B2]) * iir3mc_pkg::prod_t'(h1.y2);
      p2[6]   <= iir3mc_pkg::prod_t'(coef[iir3mc_pkg::REG_B3]) * iir3mc_pkg::prod_t'(h1.y3);
    end
  end

  // stage 3: pairwise sums, feedback terms negated, rounding bias folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (rdy3) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3    <= s2;
      q3[0] <= iir3mc_pkg::acc_t'(p2[0]) + iir3mc_pkg::acc_t'(p2[1]);
      q3[1] <= iir3mc_pkg::acc_t'(p2[2]) + iir3mc_pkg::acc_t'(p2[3]);
      q3[2] <= -iir3mc_pkg::acc_t'(p2[4]) - iir3mc_pkg::acc_t'(p2[5]);
      q3[3] <= ACC_ROUND - iir3mc_pkg::acc_t'(p2[6]);
    end
  end

  // stage 4: two partial sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (rdy4) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4    <= s3;
      t4[0] <= q3[0] + q3[1];
      t4[1] <= q3[2] + q3[3];
    end
  end

  // final sum, scale back to integer samples, saturate; zero for a clear or an out-of-range channel
  always_comb begin
    acc = t4[0] + t4[1];
    q   = acc >>> iir3mc_pkg::FRAC;
    if (q > ACC_MAX) begin
      y = iir3mc_pkg::SMP_MAX;
    end else if (q < ACC_MIN) begin
      y = iir3mc_pkg::SMP_MIN;
    end else begin
      y = q[iir3mc_pkg::SMP_W-1:0];
    end
    if (s4.func == iir3mc_pkg::FUNC_CLEAR || !s4.inr) begin
      res_next = '0;
    end else begin
      res_next = y;
    end
  end

  // writeback of the shifted history as an in-range filter word leaves stage 4
  assign retire     = s4_v && out_free;
  assign ram_we     = retire && s4.inr && s4.func == iir3mc_pkg::FUNC_FILTER;
  assign clr_retire = retire && s4.inr && s4.func == iir3mc_pkg::FUNC_CLEAR;
  assign wr_idx     = 9'(s4.chan) >= CH_LIM ? '0 : CW'(9'(s4.chan));

  always_comb begin
    wb.x1 = s4.x;
    wb.x2 = s4.h.x1;
    wb.x3 = s4.h.x2;
    wb.y1 = y;
    wb.y2 = s4.h.y1;
    wb.y3 = s4.h.y2;
  end

  // per-channel history valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      hvld <= '0;
    end else if (ram_we) begin
      hvld[wr_idx] <= 1'b1;
    end else if (clr_retire) begin
      hvld[wr_idx] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      chan_out   <= s4.chan;
      sample_out <= res_next;
    end
  end

  // interlock keeps at most one word per channel in the pipe
  a_s1_s2_distinct: assert property (@(posedge clk) disable iff (rst)
    s1_v && s2_v |-> s1.chan != s2.chan)
    else $error("two words for one channel in stages 1 and 2");

  a_s1_s4_distinct: assert property (@(posedge clk) disable iff (rst)
    s1_v && s4_v |-> s1.chan != s4.chan)
    else $error("two words for one channel in stages 1 and 4");

  // no history read of a channel in the cycle its history is written
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    ram_we && accept |-> wr_idx != rd_idx)
    else $error("history read and write collide on one channel");

  // a retired clear leaves the channel reading as zero
  a_clear_drops_valid: assert property (@(posedge clk) disable iff (rst)
    clr_retire |=> !hvld[$past(wr_idx)])
    else $error("clear did not drop the history valid bit");

endmodule
